### src/dmmh_pkg.sv
// shared types and constants for the descriptor medoid unit
package dmmh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HAM,
    ST_MED,
    ST_FETCH,
    ST_EMIT
  } state_t;

  localparam int WORD_BITS = 64;
  localparam int SLOT_BITS = 5;
  localparam int MED_BITS  = 9;

endpackage

### src/descriptor_medoid_by_median_hamming_unit.sv
// least-median hamming medoid selector for a set of binary descriptors
//
// Collects up to MAX_DESC binary descriptors (low DESC_BITS bits of the four 64-bit input
// words), one per input word, skipping words marked source_bad. A word that is kept is
// written to a descriptor memory. Then one shared hamming unit (xor, registered per-64-bit
// popcounts, sum) compares it with every earlier kept descriptor, one pair per cycle. Each
// distance goes once into a distance memory, indexed by the larger and then the smaller
// slot. A skipped or dropped word computes no pairs. When a word carries last_item, if a
// descriptor is kept and point_retired is clear, a sequencer finds the median of each
// row with a bitwise search over the distance value. Each of the DW value bits (9 for
// 256-bit descriptors) makes one pass over the row, counting entries below a trial value
// with one compare unit, one memory read per cycle. The winner's descriptor is then
// fetched from the descriptor memory. The lowest median wins, with ties going to the
// earlier slot. The result is held in an output register until it is taken; kept_count
// and the overflow flag restart for a new set when the result is loaded. Neither memory
// needs a clearing pass after reset: only slots below the kept count are ever read.
// point_retired (cfg_wr_en / cfg_wr_data) forces found = 0 with zeroed result fields.
module descriptor_medoid_by_median_hamming_unit #(
  parameter int MAX_DESC  = 32,
  parameter int DESC_BITS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] desc_word0,
  input  logic [63:0] desc_word1,
  input  logic [63:0] desc_word2,
  input  logic [63:0] desc_word3,
  input  logic        source_bad,
  input  logic        last_item,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] best_word0,
  output logic [63:0] best_word1,
  output logic [63:0] best_word2,
  output logic [63:0] best_word3,
  output logic [4:0]  best_slot,
  output logic [8:0]  best_median,
  output logic        found,
  output logic        overflowed
);

  // widths that follow from the parameters
  localparam int IW     = (MAX_DESC > 1) ? $clog2(MAX_DESC) : 1;
  localparam int KW     = $clog2(MAX_DESC + 1);
  localparam int DW     = $clog2(DESC_BITS + 1);
  localparam int MBW    = $clog2(DW);
  localparam int NCHUNK = (DESC_BITS + dmmh_pkg::WORD_BITS - 1) / dmmh_pkg::WORD_BITS;
  localparam int PADW   = NCHUNK * dmmh_pkg::WORD_BITS;
  localparam int DDEPTH = 1 << (2 * IW);
  localparam int FULLW  = 4 * dmmh_pkg::WORD_BITS;

  function automatic logic [6:0] pop64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + 7'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [DESC_BITS-1:0] cur_desc_in();
    logic [FULLW-1:0] full;
    full = {desc_word3, desc_word2, desc_word1, desc_word0};
    return full[DESC_BITS-1:0];
  endfunction

  dmmh_pkg::state_t state, state_next;

  // set bookkeeping
  logic [KW-1:0]        kept_count;
  logic                 overflow_seen;
  logic                 point_retired;

  // current word
  logic [DESC_BITS-1:0] cur_desc;
  logic                 cur_last;
  logic [KW-1:0]        cur_slot;     // pairs to compute for this word

  // memories
  logic [DESC_BITS-1:0] store_mem [MAX_DESC];
  logic [DESC_BITS-1:0] store_q;
  logic [IW-1:0]        store_raddr;
  logic [DW-1:0]        dist_mem [DDEPTH];
  logic [DW-1:0]        dist_q;
  logic [2*IW-1:0]      dist_raddr;

  // hamming sweep pipeline
  logic [KW-1:0]        hj;
  logic                 s1_v, s2_v;
  logic [IW-1:0]        s1_j, s2_j;
  logic [6:0]           part [NCHUNK];
  logic [PADW-1:0]      diff;
  logic [DW-1:0]        ham_sum;
  logic                 ham_issue, ham_done;

  // median search
  logic [KW-1:0]        mi, mj, cnt, m_half;
  logic [MBW-1:0]       mb;
  logic                 rd_v;
  logic [IW-1:0]        rd_j;
  logic [DW-1:0]        res, trial, res_upd, row_val;
  logic [DW-1:0]        best_med;
  logic [IW-1:0]        best_idx;
  logic                 med_issue, bit_done, row_last, med_done;
  logic                 sel_any, found_q;

  // handshake
  logic                 in_acc, keep_word, emit_load;

  assign in_acc    = in_valid && !in_stall;
  assign keep_word = !source_bad && (kept_count < KW'(MAX_DESC));
  assign sel_any   = (kept_count != '0) && !point_retired;

  assign diff = PADW'(cur_desc ^ store_q);
  always_comb begin
    ham_sum = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      ham_sum = ham_sum + DW'(part[c]);
    end
  end

  assign ham_issue = (state == dmmh_pkg::ST_HAM) && (hj < cur_slot);
  assign ham_done  = (hj == cur_slot) && !s1_v && !s2_v;

  assign m_half    = (kept_count - KW'(1)) >> 1;
  assign trial     = res | (DW'(1) << mb);
  assign row_val   = (rd_j == mi[IW-1:0]) ? '0 : dist_q;
  assign res_upd   = (cnt <= m_half) ? trial : res;
  assign med_issue = (state == dmmh_pkg::ST_MED) && (mj < kept_count);
  assign bit_done  = (mj == kept_count) && !rd_v;
  assign row_last  = (mi == kept_count - KW'(1));
  assign med_done  = bit_done && (mb == '0) && row_last;

  // read addresses: larger slot first in the distance memory
  always_comb begin
    if (mi[IW-1:0] > mj[IW-1:0]) begin
      dist_raddr = {mi[IW-1:0], mj[IW-1:0]};
    end else begin
      dist_raddr = {mj[IW-1:0], mi[IW-1:0]};
    end
    store_raddr = (state == dmmh_pkg::ST_HAM) ? hj[IW-1:0] : best_idx;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dmmh_pkg::ST_IDLE:  if (in_acc) state_next = dmmh_pkg::ST_HAM;
      dmmh_pkg::ST_HAM: begin
        if (ham_done) begin
          if (!cur_last)    state_next = dmmh_pkg::ST_IDLE;
          else if (sel_any) state_next = dmmh_pkg::ST_MED;
          else              state_next = dmmh_pkg::ST_EMIT;
        end
      end
      dmmh_pkg::ST_MED:   if (med_done) state_next = dmmh_pkg::ST_FETCH;
      dmmh_pkg::ST_FETCH: state_next = dmmh_pkg::ST_EMIT;
      dmmh_pkg::ST_EMIT:  if (!out_valid || !out_stall) state_next = dmmh_pkg::ST_IDLE;
      default:            state_next = dmmh_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = (state != dmmh_pkg::ST_IDLE);
    emit_load = (state == dmmh_pkg::ST_EMIT) && (!out_valid || !out_stall);
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && keep_word) begin
      store_mem[kept_count[IW-1:0]] <= cur_desc_in();
    end
    store_q <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (s2_v && state == dmmh_pkg::ST_HAM) begin
      dist_mem[{cur_slot[IW-1:0], s2_j}] <= ham_sum;
    end
    dist_q <= dist_mem[dist_raddr];
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dmmh_pkg::ST_IDLE;
      kept_count    <= '0;
      overflow_seen <= 1'b0;
      point_retired <= 1'b0;
      out_valid     <= 1'b0;
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      rd_v          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        point_retired <= cfg_wr_data;
      end

      // accept a word
      if (in_acc) begin
        cur_desc <= cur_desc_in();
        cur_last <= last_item;
        hj       <= '0;
        if (keep_word) begin
          cur_slot   <= kept_count;
          kept_count <= kept_count + KW'(1);
        end else begin
          cur_slot <= '0;
          if (!source_bad) overflow_seen <= 1'b1;
        end
      end

      // hamming sweep: read, popcount, sum and write
      s1_v <= ham_issue;
      s1_j <= hj[IW-1:0];
      if (ham_issue) hj <= hj + KW'(1);
      s2_v <= s1_v;
      s2_j <= s1_j;
      for (int c = 0; c < NCHUNK; c++) begin
        part[c] <= pop64(diff[c*dmmh_pkg::WORD_BITS +: dmmh_pkg::WORD_BITS]);
      end

      // median search, one row entry per cycle
      if (state != dmmh_pkg::ST_MED) begin
        mi   <= '0;
        mj   <= '0;
        mb   <= MBW'(DW - 1);
        res  <= '0;
        cnt  <= '0;
        rd_v <= 1'b0;
      end else begin
        rd_v <= med_issue;
        rd_j <= mj[IW-1:0];
        if (med_issue) mj <= mj + KW'(1);
        if (rd_v && row_val < trial) cnt <= cnt + KW'(1);
        if (bit_done) begin
          cnt <= '0;
          mj  <= '0;
          if (mb == '0) begin
            if (mi == '0 || res_upd < best_med) begin
              best_med <= res_upd;
              best_idx <= mi[IW-1:0];
            end
            mi  <= mi + KW'(1);
            mb  <= MBW'(DW - 1);
            res <= '0;
          end else begin
            res <= res_upd;
            mb  <= mb - MBW'(1);
          end
        end
      end

      if (state == dmmh_pkg::ST_HAM && ham_done) begin
        found_q <= sel_any;
      end

      // result register
      if (emit_load) begin
        out_valid     <= 1'b1;
        kept_count    <= '0;
        overflow_seen <= 1'b0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit_load) begin
      if (found_q) begin
        {best_word3, best_word2, best_word1, best_word0} <= FULLW'(store_q);
        best_slot   <= dmmh_pkg::SLOT_BITS'(best_idx);
        best_median <= dmmh_pkg::MED_BITS'(best_med);
      end else begin
        {best_word3, best_word2, best_word1, best_word0} <= '0;
        best_slot   <= '0;
        best_median <= '0;
      end
      found      <= found_q;
      overflowed <= overflow_seen;
    end
  end

endmodule
